// ===== hdl/hsv_pkg.sv =====
// ============================================================================
// hsv_pkg
// Shared constants for the HSV hue rotation and saturation scaling pipeline.
// ============================================================================
package hsv_pkg;

  localparam int CHANNEL_BITS_DEFAULT = 8;

  // Hue resolution: 256 steps per sextant, 1536 per turn
  localparam int HUE_SEXTANT = 256;
  localparam int HUE_TURN    = 1536;
  localparam int HUE_BITS    = 11;

  // Quotient bits of the hue fraction divider (2 * 256 plus one rounding bit)
  localparam int FRAC_Q = 10;

  // Configuration port
  localparam int CFG_DATA_BITS  = 12;
  localparam int CFG_INDEX_BITS = 2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_HUE_OFFSET      = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SATURATION_GAIN = 2'd1;
  localparam logic [CFG_DATA_BITS-1:0]  SAT_GAIN_RESET      = 12'd256;

  // Channel holding the maximum
  localparam logic [1:0] MAX_RED   = 2'd0;
  localparam logic [1:0] MAX_GREEN = 2'd1;
  localparam logic [1:0] MAX_BLUE  = 2'd2;

  // Hue sextants
  localparam logic [2:0] SEXT_RED_YELLOW    = 3'd0;
  localparam logic [2:0] SEXT_YELLOW_GREEN  = 3'd1;
  localparam logic [2:0] SEXT_GREEN_CYAN    = 3'd2;
  localparam logic [2:0] SEXT_CYAN_BLUE     = 3'd3;
  localparam logic [2:0] SEXT_BLUE_MAGENTA  = 3'd4;

endpackage

// ===== hdl/hsv_hue_saturation_adjust.sv =====
// ============================================================================
// hsv_hue_saturation_adjust
// Rotates the hue and scales the saturation of an RGB pixel stream in HSV.
// ============================================================================
// Usage:
//   Pixels enter on pixel_in with in_valid/in_ready and leave on pixel_out
//   with out_valid/out_ready; a request moves when valid and ready are both
//   high. Red sits in the top channel, blue in the low channel.
//   Throughput is one pixel per clock while the output is not stalled. The
//   pipeline holds the two bit-per-stage dividers (hue fraction and
//   saturation) followed by the multiply and rounding stages of the HSV to
//   RGB conversion.
//   Every stage holds a valid bit and takes a new request whenever it is
//   empty or its successor moves, so bubbles close up while the output is
//   stalled and no request is lost or repeated.
//   Configuration: cfg_write with cfg_index 0 loads hue_offset (signed, in
//   1/1536 turn), index 1 loads saturation_gain (unsigned Q4.8); other
//   indexes are ignored. Write only while the pipeline is empty.
//   Reset empties the pipeline and sets offset 0 and gain 1.0.
// ============================================================================
module hsv_hue_saturation_adjust #(
  parameter int CHANNEL_BITS = hsv_pkg::CHANNEL_BITS_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [3*CHANNEL_BITS-1:0]             pixel_in,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [3*CHANNEL_BITS-1:0]             pixel_out,
  input  logic                                  cfg_write,
  input  logic [hsv_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [hsv_pkg::CFG_DATA_BITS-1:0]     cfg_data
);
  import hsv_pkg::*;

  localparam int CB      = CHANNEL_BITS;
  localparam int M       = (1 << CB) - 1;
  localparam int HALF_M  = (M - 1) / 2;
  localparam int SAT_Q   = CB + 1;
  localparam int DS      = (FRAC_Q > SAT_Q) ? FRAC_Q : SAT_Q;
  localparam int ST_HUE  = DS + 1;
  localparam int ST_PROD = DS + 2;
  localparam int ST_CLMP = DS + 3;
  localparam int ST_MUL  = DS + 4;
  localparam int ST_MUL2 = DS + 5;
  localparam int ST_DIV  = DS + 6;
  localparam int ST_OUT  = DS + 7;
  localparam int NS      = DS + 8;

  typedef struct packed {
    logic [3*CB-1:0] pix;
    logic            grey;
    logic [CB-1:0]   mx;
    logic [1:0]      code;
    logic            neg;
    logic [CB-1:0]   delta;
    logic [CB+9:0]   remf;
    logic [FRAC_Q-1:0] qf;
    logic [2*CB+1:0] rems;
    logic [SAT_Q-1:0] qs;
    logic [CB-1:0]   sat;
    logic [HUE_BITS-1:0] hue;
    logic [CB+11:0]  prod;
    logic [CB-1:0]   s2;
    logic [2*CB-1:0] mp;
    logic [CB+7:0]   sq;
    logic [CB+7:0]   st;
    logic [2*CB-1:0] yp;
    logic [2*CB+7:0] zq;
    logic [2*CB+7:0] zt;
    logic [CB-1:0]   pv;
    logic [2*CB-1:0] yq;
    logic [2*CB-1:0] yt;
    logic [3*CB-1:0] pout;
  } pipe_t;

  // Divide by M = 2^CB - 1 without a divider; exact for y < M * 2^CB
  function automatic logic [CB-1:0] div_m(input logic [2*CB-1:0] y);
    logic [2*CB:0] s;
    s = {1'b0, y} + (2*CB+1)'(y >> CB) + (2*CB+1)'(1);
    return CB'(s >> CB);
  endfunction

  logic [HUE_BITS-1:0]      hue_offset;
  logic [CFG_DATA_BITS-1:0] saturation_gain;
  logic signed [12:0]       off_next;

  logic [NS-1:0] valid;
  logic [NS:0]   rdy;
  pipe_t         data [NS];
  pipe_t         nxt  [NS];

  // Configuration: hold the offset already reduced to one turn
  always_comb begin
    off_next = signed'({cfg_data[CFG_DATA_BITS-1], cfg_data});
    if (off_next < 0) off_next = off_next + 13'sd1536;
    if (off_next < 0) off_next = off_next + 13'sd1536;
    if (off_next >= 13'sd1536) off_next = off_next - 13'sd1536;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hue_offset      <= '0;
      saturation_gain <= SAT_GAIN_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_HUE_OFFSET:      hue_offset      <= off_next[HUE_BITS-1:0];
        REG_SATURATION_GAIN: saturation_gain <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage ready: a stage moves when empty or when its successor moves
  always_comb begin
    rdy[NS] = out_ready;
    for (int k = NS - 1; k >= 0; k--) begin
      rdy[k] = !valid[k] || rdy[k+1];
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = valid[NS-1];
  assign pixel_out = data[NS-1].pout;

  // Entry stage: max, min, hue sextant and difference
  always_comb begin
    logic [CB-1:0] r, g, b, mn;
    r = pixel_in[3*CB-1:2*CB];
    g = pixel_in[2*CB-1:CB];
    b = pixel_in[CB-1:0];
    nxt[0]     = '0;
    nxt[0].pix = pixel_in;
    nxt[0].mx  = r;
    if (g > nxt[0].mx) nxt[0].mx = g;
    if (b > nxt[0].mx) nxt[0].mx = b;
    mn = r;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    nxt[0].delta = nxt[0].mx - mn;
    nxt[0].grey  = (nxt[0].delta == '0);
    if (nxt[0].mx == r) begin
      nxt[0].code = MAX_RED;
      nxt[0].neg  = g < b;
      nxt[0].remf = {(nxt[0].neg ? b - g : g - b), 10'b0};
    end else if (nxt[0].mx == g) begin
      nxt[0].code = MAX_GREEN;
      nxt[0].neg  = b < r;
      nxt[0].remf = {(nxt[0].neg ? r - b : b - r), 10'b0};
    end else begin
      nxt[0].code = MAX_BLUE;
      nxt[0].neg  = r < g;
      nxt[0].remf = {(nxt[0].neg ? g - r : r - g), 10'b0};
    end
    // 2 * f * 256 for the hue fraction; 2 * delta * M for the saturation
    nxt[0].remf = nxt[0].remf >> 1;
    nxt[0].rems = ({2'b0, nxt[0].delta, CB'(0)} - (2*CB+2)'(nxt[0].delta)) << 1;
  end

  // Divider stages: one quotient bit per stage for each quotient; the shorter one idles in the leading stages
  for (genvar i = 1; i <= DS; i++) begin : g_div
    localparam int J = DS - i;
    always_comb begin
      logic [CB+9:0]   dfr;
      logic [2*CB+1:0] dsa;
      dfr    = (CB+10)'(data[i-1].delta) << J;
      dsa    = (2*CB+2)'(data[i-1].mx) << J;
      nxt[i] = data[i-1];
      if (J < FRAC_Q && data[i-1].remf >= dfr) begin
        nxt[i].remf = data[i-1].remf - dfr;
        nxt[i].qf   = data[i-1].qf | (FRAC_Q'(1) << J);
      end
      if (J < SAT_Q && data[i-1].rems >= dsa) begin
        nxt[i].rems = data[i-1].rems - dsa;
        nxt[i].qs   = data[i-1].qs | (SAT_Q'(1) << J);
      end
    end
  end

  // Rounding, hue rotation and wrap
  always_comb begin
    logic [FRAC_Q:0]     qf1;
    logic [SAT_Q:0]      qs1;
    logic [8:0]          frac;
    logic signed [12:0]  h0;
    logic [11:0]         hsum;
    qf1  = {1'b0, data[DS].qf} + (FRAC_Q+1)'(1);
    qs1  = {1'b0, data[DS].qs} + (SAT_Q+1)'(1);
    frac = 9'(qf1 >> 1);
    nxt[ST_HUE]     = data[DS];
    nxt[ST_HUE].sat = CB'(qs1 >> 1);
    h0 = signed'(13'({data[DS].code, 9'b0}));
    if (data[DS].neg) h0 = h0 - signed'(13'(frac));
    else              h0 = h0 + signed'(13'(frac));
    if (h0 < 0) h0 = h0 + 13'sd1536;
    hsum = 12'(h0[HUE_BITS-1:0]) + 12'(hue_offset);
    if (hsum >= 12'(HUE_TURN)) hsum = hsum - 12'(HUE_TURN);
    nxt[ST_HUE].hue = hsum[HUE_BITS-1:0];
  end

  // Saturation gain product
  always_comb begin
    nxt[ST_PROD]      = data[ST_HUE];
    nxt[ST_PROD].prod = (CB+12)'(data[ST_HUE].sat) * (CB+12)'(saturation_gain);
  end

  // Round and clamp the scaled saturation
  always_comb begin
    logic [CB+11:0] sr;
    sr = (data[ST_PROD].prod + (CB+12)'(128)) >> 8;
    nxt[ST_CLMP]    = data[ST_PROD];
    nxt[ST_CLMP].s2 = (sr > (CB+12)'(M)) ? CB'(M) : sr[CB-1:0];
  end

  // First products of the HSV to RGB conversion
  always_comb begin
    logic [CB-1:0] s2;
    logic [7:0]    fr;
    s2 = data[ST_CLMP].s2;
    fr = data[ST_CLMP].hue[7:0];
    nxt[ST_MUL]    = data[ST_CLMP];
    nxt[ST_MUL].mp = (2*CB)'(data[ST_CLMP].mx) * (2*CB)'(CB'(M) - s2);
    nxt[ST_MUL].sq = (CB+8)'(s2) * (CB+8)'(fr);
    nxt[ST_MUL].st = (CB+8)'(s2) * ((CB+8)'(HUE_SEXTANT) - (CB+8)'(fr));
  end

  // Scale by V for q and t; bias p for rounding
  always_comb begin
    logic [CB+7:0] full;
    full = (CB+8)'(HUE_SEXTANT * M);
    nxt[ST_MUL2]    = data[ST_MUL];
    nxt[ST_MUL2].yp = data[ST_MUL].mp + (2*CB)'(HALF_M);
    nxt[ST_MUL2].zq = (2*CB+8)'(data[ST_MUL].mx) * (2*CB+8)'(full - data[ST_MUL].sq);
    nxt[ST_MUL2].zt = (2*CB+8)'(data[ST_MUL].mx) * (2*CB+8)'(full - data[ST_MUL].st);
  end

  // Divide p by M; round q and t by 256 ahead of their divide by M
  always_comb begin
    logic [2*CB+7:0] aq, at;
    aq = data[ST_MUL2].zq + (2*CB+8)'(128 * M);
    at = data[ST_MUL2].zt + (2*CB+8)'(128 * M);
    nxt[ST_DIV]    = data[ST_MUL2];
    nxt[ST_DIV].pv = div_m(data[ST_MUL2].yp);
    nxt[ST_DIV].yq = aq[2*CB+7:8];
    nxt[ST_DIV].yt = at[2*CB+7:8];
  end

  // Finish q and t, pick the channel order by sextant
  always_comb begin
    logic [CB-1:0] v, p, q, t;
    v = data[ST_DIV].mx;
    p = data[ST_DIV].pv;
    q = div_m(data[ST_DIV].yq);
    t = div_m(data[ST_DIV].yt);
    nxt[ST_OUT] = data[ST_DIV];
    case (data[ST_DIV].hue[HUE_BITS-1:8])
      SEXT_RED_YELLOW:   nxt[ST_OUT].pout = {v, t, p};
      SEXT_YELLOW_GREEN: nxt[ST_OUT].pout = {q, v, p};
      SEXT_GREEN_CYAN:   nxt[ST_OUT].pout = {p, v, t};
      SEXT_CYAN_BLUE:    nxt[ST_OUT].pout = {p, q, v};
      SEXT_BLUE_MAGENTA: nxt[ST_OUT].pout = {t, p, v};
      default:           nxt[ST_OUT].pout = {v, p, q};
    endcase
    // Grey has no hue: pass the pixel through
    if (data[ST_DIV].grey) nxt[ST_OUT].pout = data[ST_DIV].pix;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (rdy[0]) valid[0] <= in_valid;
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) valid[k] <= valid[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NS; k++) begin
      if (rdy[k]) data[k] <= nxt[k];
    end
  end

  // Hue fraction divider leaves a remainder below the divisor
  a_frac_rem: assert property (@(posedge clk) disable iff (rst)
    valid[DS] && !data[DS].grey |-> data[DS].remf < (CB+10)'(data[DS].delta))
    else $error("hue fraction remainder not below delta");

  a_hue_range: assert property (@(posedge clk) disable iff (rst)
    valid[ST_HUE] |-> data[ST_HUE].hue < HUE_BITS'(HUE_TURN))
    else $error("hue outside one turn");

  a_sat_clamp: assert property (@(posedge clk) disable iff (rst)
    valid[ST_CLMP] |-> data[ST_CLMP].s2 <= CB'(M))
    else $error("scaled saturation above full scale");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) && !rst |-> !out_valid)
    else $error("output valid right after reset");

endmodule
